// File: rtl/egf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the encoder glitch filter.
// No dependencies; every other file of the block refers to it by scoped names.
package egf_pkg;

  // Fixed port widths of the sample and result channels
  localparam int ANGLE_W = 14;

  // Configuration register file
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 15;
  localparam int SPEED_LIMIT_W  = 14;
  localparam int CHANGE_LIMIT_W = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_LIMIT = CFG_INDEX_W'(1);

  localparam logic [SPEED_LIMIT_W-1:0]  SPEED_LIMIT_RESET  = SPEED_LIMIT_W'(2053);
  localparam logic [CHANGE_LIMIT_W-1:0] CHANGE_LIMIT_RESET = CHANGE_LIMIT_W'(513);

  // Steps are held in fixed point with this many fraction bits
  localparam int FRAC_BITS = 8;

  // Shared add/subtract unit operation
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

endpackage

// File: rtl/egf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw samples and filtered results.
// Depends on egf_pkg for the angle width.
interface egf_in_if;
  logic                        valid;
  logic                        ready;
  logic [egf_pkg::ANGLE_W-1:0] raw_angle;

  modport source (output valid, output raw_angle, input ready);
  modport sink   (input valid, input raw_angle, output ready);
endinterface

interface egf_out_if;
  logic                        valid;
  logic                        ready;
  logic [egf_pkg::ANGLE_W-1:0] filtered_angle;
  logic                        anomaly;

  modport source (output valid, output filtered_angle, output anomaly, input ready);
  modport sink   (input valid, input filtered_angle, input anomaly, output ready);
endinterface

// File: rtl/egf_addsub.sv
`timescale 1ns / 1ps
// Shared add/subtract unit: one carry chain, operand b inverted for subtract.
// Depends on egf_pkg for the operation codes.
module egf_addsub #(
  parameter int W = 24
) (
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  egf_pkg::alu_op_t op,
  output logic [W-1:0]     y
);

  logic          sub;
  logic [W-1:0]  b_inv;

  assign sub   = (op == egf_pkg::ALU_SUB);
  assign b_inv = b ^ {W{sub}};
  assign y     = a + b_inv + W'(sub);

endmodule

// File: rtl/encoder_glitch_filter.sv
`timescale 1ns / 1ps
// Encoder glitch filter top level: sequencer, history rings, limits, output register.
// Depends on egf_pkg, egf_if (egf_in_if, egf_out_if) and egf_addsub.
//
// One raw angle is taken per transaction and one result is given back for it. The block
// takes a sample only when its sequencer is idle; a finished result waits in an output
// register, so the next sample is taken while it is still pending. A sample that passes
// (fill phase or within limits) goes from the idle state through the check and finish
// states back to idle. A replaced sample adds a sum state, in which the shared adder
// sums the step ring one slot a cycle, a prep state, in which the same adder forms the
// magnitude of the sum plus half the divisor, a multiply state that multiplies it by the
// reciprocal of HISTORY_DEPTH-1, and an estimate state.
// The last result stage holds when the output register is still occupied.
module encoder_glitch_filter #(
  parameter int HISTORY_DEPTH = 10,
  parameter int ANGLE_BITS    = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [egf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [egf_pkg::CFG_DATA_W-1:0]     cfg_data,
  egf_in_if.sink                             sample,
  egf_out_if.source                          result
);

  localparam int AB      = ANGLE_BITS;
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int DLW     = AB + 2;                       // raw angle difference
  localparam int SW      = AB + 1 + egf_pkg::FRAC_BITS;  // fixed point step
  localparam int CW      = (AB + 10 > 25) ? AB + 10 : 25; // limit compare width
  localparam int SUMW    = SW + $clog2(HISTORY_DEPTH);
  localparam int DIVISOR = HISTORY_DEPTH - 1;
  localparam int DIV_SH  = SUMW + $clog2(DIVISOR);       // reciprocal scale
  localparam int MW      = SUMW + 1;                     // reciprocal width
  localparam int PW      = SUMW + MW;                    // product width
  localparam int HALF_I  = 1 << (AB - 1);
  localparam int SPAN_I  = 1 << AB;
  localparam int ROUND_I = 1 << (egf_pkg::FRAC_BITS - 1);
  localparam longint RECIP_I =
    ((longint'(1) << DIV_SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

  localparam logic signed [DLW-1:0] HALF = DLW'(HALF_I);
  localparam logic signed [DLW-1:0] SPAN = DLW'(SPAN_I);
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [MW-1:0]         RECIP = MW'(RECIP_I);
  localparam logic [SUMW-1:0]       HALF_DIV = SUMW'(DIVISOR / 2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_EST    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;

  // Configuration
  logic [egf_pkg::SPEED_LIMIT_W-1:0]  speed_limit;
  logic [egf_pkg::CHANGE_LIMIT_W-1:0] change_limit;

  // History rings and their control
  logic [AB-1:0]        angle_hist [HISTORY_DEPTH];
  logic signed [SW-1:0] step_hist  [HISTORY_DEPTH];
  logic [SLOT_W-1:0]    slot;
  logic                 full;
  logic signed [SW-1:0] prev_step;

  // Working registers
  logic [AB-1:0]        angle_reg;
  logic [AB-1:0]        last_reg;
  logic signed [SW-1:0] step_q_reg;
  logic                 anomaly_reg;
  logic [AB-1:0]        result_angle;
  logic [SUMW-1:0]      acc;
  logic [SLOT_W-1:0]    sum_idx;
  logic [SUMW-1:0]      num;
  logic [PW-1:0]        prod;

  // Output register
  logic                 out_valid;
  logic [AB-1:0]        out_angle;
  logic                 out_anomaly;

  // Combinational
  logic [SLOT_W-1:0]    prev_slot;
  logic [AB-1:0]        last_angle;
  logic signed [DLW-1:0] diff_raw;
  logic signed [DLW-1:0] step_w;
  logic [DLW-1:0]       abs_step;
  logic signed [SW-1:0] step_q_w;
  logic signed [CW-1:0] dq;
  logic [CW-1:0]        abs_dq;
  logic                 speed_hit;
  logic                 change_hit;
  logic                 anomaly_w;
  logic [SUMW-1:0]      unit_a;
  logic [SUMW-1:0]      unit_b;
  logic [SUMW-1:0]      unit_y;
  egf_pkg::alu_op_t     unit_op;
  logic                 acc_neg;
  logic [SW-1:0]        q_mag;
  logic [SW-1:0]        tick_mag;
  logic [AB-1:0]        ticks_lo;
  logic [AB-1:0]        ticks;
  logic signed [SW-1:0] avg_q;
  logic                 commit;

  assign sample.ready          = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.filtered_angle = egf_pkg::ANGLE_W'(out_angle);
  assign result.anomaly        = out_anomaly;

  assign commit = (state == S_FINISH) && (!out_valid || result.ready);

  // Step from the last stored angle to the new sample, wrapped to half a turn
  assign prev_slot  = (slot == '0) ? LAST_SLOT : slot - SLOT_W'(1);
  assign last_angle = angle_hist[prev_slot];

  always_comb begin
    diff_raw = $signed({2'b00, angle_reg}) - $signed({2'b00, last_angle});
    step_w   = diff_raw;
    if (diff_raw > HALF) begin
      step_w = diff_raw - SPAN;
    end else if (diff_raw < -HALF) begin
      step_w = diff_raw + SPAN;
    end
  end

  assign step_q_w   = SW'(step_w) <<< egf_pkg::FRAC_BITS;
  assign abs_step   = step_w[DLW-1] ? DLW'(-step_w) : DLW'(step_w);
  assign dq         = CW'(step_q_w) - CW'(prev_step);
  assign abs_dq     = dq[CW-1] ? CW'(-dq) : CW'(dq);
  assign speed_hit  = CW'(abs_step) > CW'(speed_limit);
  assign change_hit = abs_dq > CW'({change_limit, {egf_pkg::FRAC_BITS{1'b0}}});
  assign anomaly_w  = full && (speed_hit || change_hit);

  // Shared unit: sums the step ring, then forms |sum| + divisor/2 for the rounding divide
  assign acc_neg = acc[SUMW-1];

  always_comb begin
    if (state == S_PREP) begin
      unit_a  = acc_neg ? HALF_DIV : acc;
      unit_b  = acc_neg ? acc : HALF_DIV;
      unit_op = acc_neg ? egf_pkg::ALU_SUB : egf_pkg::ALU_ADD;
    end else begin
      unit_a  = acc;
      unit_b  = SUMW'(step_hist[sum_idx]);
      unit_op = egf_pkg::ALU_ADD;
    end
  end

  egf_addsub #(
    .W (SUMW)
  ) u_addsub (
    .a  (unit_a),
    .b  (unit_b),
    .op (unit_op),
    .y  (unit_y)
  );

  // Rounding of the average and of the tick estimate, halves away from zero
  assign q_mag    = prod[DIV_SH +: SW];
  assign avg_q    = acc_neg ? -$signed(q_mag) : $signed(q_mag);
  assign tick_mag = (q_mag + SW'(ROUND_I)) >> egf_pkg::FRAC_BITS;
  assign ticks_lo = AB'(tick_mag);
  assign ticks    = acc_neg ? -ticks_lo : ticks_lo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit  <= egf_pkg::SPEED_LIMIT_RESET;
      change_limit <= egf_pkg::CHANGE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        egf_pkg::REG_SPEED_LIMIT:  speed_limit  <= cfg_data[egf_pkg::SPEED_LIMIT_W-1:0];
        egf_pkg::REG_CHANGE_LIMIT: change_limit <= cfg_data[egf_pkg::CHANGE_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK:  state <= anomaly_w ? S_SUM : S_FINISH;
        S_SUM: begin
          if (sum_idx == LAST_SLOT) begin
            state <= S_PREP;
          end
        end
        S_PREP:   state <= S_MUL;
        S_MUL:    state <= S_EST;
        S_EST:    state <= S_FINISH;
        S_FINISH: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        angle_reg <= AB'(sample.raw_angle);
      end
      S_CHECK: begin
        last_reg     <= last_angle;
        step_q_reg   <= step_q_w;
        anomaly_reg  <= anomaly_w;
        result_angle <= angle_reg;
        acc          <= '0;
        sum_idx      <= '0;
      end
      S_SUM: begin
        // skip the oldest step, which sits in the slot about to be overwritten
        if (sum_idx != prev_slot) begin
          acc <= unit_y;
        end
        sum_idx <= sum_idx + SLOT_W'(1);
      end
      S_PREP: begin
        num <= unit_y;
      end
      S_MUL: begin
        // divide by the constant through its scaled reciprocal
        prod <= PW'(num) * PW'(RECIP);
      end
      S_EST: begin
        step_q_reg   <= avg_q;
        result_angle <= last_reg + ticks;
      end
      default: ;
    endcase
  end

  // History rings: advance on commit of each result
  always_ff @(posedge clk) begin
    if (commit) begin
      angle_hist[slot] <= result_angle;
      if (full || slot != '0) begin
        step_hist[prev_slot] <= step_q_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      full      <= 1'b0;
      prev_step <= '0;
    end else if (commit) begin
      slot <= (slot == LAST_SLOT) ? '0 : slot + SLOT_W'(1);
      if (slot == LAST_SLOT) begin
        full <= 1'b1;
      end
      if (full) begin
        prev_step <= step_q_reg;
      end
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_angle   <= result_angle;
      out_anomaly <= anomaly_reg;
    end
  end

endmodule

// File: tb/sv/egf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the encoder glitch filter: mirrors the filter state, predicts each result.
// Depends on egf_pkg and the egf_in_if / egf_out_if channel interfaces.
module egf_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [egf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [egf_pkg::CFG_DATA_W-1:0]  cfg_data,
  egf_in_if                               smp,
  egf_out_if                              res,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_seen,
  output int                              estimates_seen
);

  localparam int     HIST     = 10;
  localparam longint SPAN     = longint'(1) << egf_pkg::ANGLE_W;
  localparam longint FRAC_ONE = longint'(1) << egf_pkg::FRAC_BITS;

  typedef struct packed {
    logic [egf_pkg::ANGLE_W-1:0] angle;
    logic                        glitch;
  } filt_t;

  logic [egf_pkg::ANGLE_W-1:0] angle_ring [HIST];
  longint                      step_ring  [HIST];
  int                          slot;
  bit                          ring_full;
  longint                      last_step;
  longint                      speed_lim;
  longint                      change_lim;

  filt_t filt_q [$];
  int    bad_cnt;
  int    res_cnt;
  int    est_cnt;

  function automatic longint tick_delta(longint from, longint to);
    longint d;
    d = to - from;
    if (d > SPAN / 2) d -= SPAN;
    if (d < -(SPAN / 2)) d += SPAN;
    return d;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // halves away from zero
  function automatic longint round_div(longint num, longint den);
    longint q;
    q = (2 * magnitude(num) + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic filt_t filter_sample(logic [egf_pkg::ANGLE_W-1:0] raw);
    longint prior, step, step_q, sum, avg_q, ticks, est;
    int     back;
    filt_t  r;
    r.angle  = raw;
    r.glitch = 1'b0;
    back     = (slot + HIST - 1) % HIST;
    if (!ring_full) begin
      angle_ring[slot] = raw;
      if (slot > 0) step_ring[slot-1] = tick_delta(angle_ring[slot-1], raw) * FRAC_ONE;
      slot++;
      if (slot >= HIST) begin
        ring_full = 1'b1;
        slot      = 0;
      end
    end else begin
      prior  = angle_ring[back];
      step   = tick_delta(prior, raw);
      step_q = step * FRAC_ONE;
      if (magnitude(step) > speed_lim) r.glitch = 1'b1;
      if (magnitude(step_q - last_step) > change_lim * FRAC_ONE) r.glitch = 1'b1;
      if (r.glitch) begin
        // the slot behind the write pointer holds the oldest step: skip it
        sum = 0;
        for (int i = 0; i < HIST; i++)
          if (i != back) sum += step_ring[i];
        avg_q = round_div(sum, HIST - 1);
        ticks = round_div(avg_q, FRAC_ONE);
        est   = (prior + ticks) % SPAN;
        if (est < 0) est += SPAN;
        r.angle = est[egf_pkg::ANGLE_W-1:0];
        step_q  = avg_q;
      end
      angle_ring[slot] = r.angle;
      step_ring[back]  = step_q;
      last_step        = step_q;
      slot             = (slot + 1) % HIST;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    filt_t want;
    if (rst) begin
      for (int i = 0; i < HIST; i++) begin
        angle_ring[i] = '0;
        step_ring[i]  = 0;
      end
      slot       = 0;
      ring_full  = 1'b0;
      last_step  = 0;
      speed_lim  = longint'(egf_pkg::SPEED_LIMIT_RESET);
      change_lim = longint'(egf_pkg::CHANGE_LIMIT_RESET);
      filt_q.delete();
      bad_cnt = 0;
      res_cnt = 0;
      est_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          egf_pkg::REG_SPEED_LIMIT:
            speed_lim = longint'(cfg_data[egf_pkg::SPEED_LIMIT_W-1:0]);
          egf_pkg::REG_CHANGE_LIMIT:
            change_lim = longint'(cfg_data[egf_pkg::CHANGE_LIMIT_W-1:0]);
          default: ;
        endcase
      end
      // compare before predicting so a same-cycle transaction cannot match itself
      if (res.valid && res.ready) begin
        res_cnt++;
        if (res.anomaly) est_cnt++;
        if (filt_q.size() == 0) begin
          $display("%t: unexpected result: angle %0d anomaly %0b", $time,
                   res.filtered_angle, res.anomaly);
          bad_cnt++;
        end else begin
          want = filt_q.pop_front();
          if (res.filtered_angle !== want.angle) begin
            $display("%t: filtered_angle mismatch: expected %0d, actual %0d", $time,
                     want.angle, res.filtered_angle);
            bad_cnt++;
          end
          if (res.anomaly !== want.glitch) begin
            $display("%t: anomaly mismatch: expected %0b, actual %0b", $time,
                     want.glitch, res.anomaly);
            bad_cnt++;
          end
        end
      end
      if (smp.valid && smp.ready) filt_q.push_back(filter_sample(smp.raw_angle));
    end
    mismatches     <= bad_cnt;
    outstanding    <= filt_q.size();
    results_seen   <= res_cnt;
    estimates_seen <= est_cnt;
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the encoder glitch filter bench: clock, reset, register writes, sample traffic.
// Depends on egf_pkg, egf_if, encoder_glitch_filter and egf_checker.
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int ANGLE_MAX   = (1 << egf_pkg::ANGLE_W) - 1;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [egf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [egf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  bit                              no_idle = 1'b0;

  int mismatches, outstanding, results_seen, estimates_seen;
  int samples_sent;
  int reg_writes;
  int stall_cycles;
  int pos;

  int directed_seq [0:19] = '{0, 16383, 8191, 0, 8192, 16383, 16383, 100, 200, 300,
                              400, 500, 600, 9000, 700, 16383, 0, 800, 850, 900};

  egf_in_if  smp_ch ();
  egf_out_if res_ch ();

  encoder_glitch_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp_ch),
    .result    (res_ch)
  );

  egf_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .smp            (smp_ch),
    .res            (res_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .estimates_seen (estimates_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) res_ch.ready <= !rst && (no_idle || $urandom_range(99) >= 16);

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [egf_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[egf_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  task automatic push_sample(input int angle);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 16) begin
      smp_ch.valid <= 1'b0;
      @(negedge clk);
    end
    smp_ch.valid     <= 1'b1;
    smp_ch.raw_angle <= angle[egf_pkg::ANGLE_W-1:0];
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // drop valid and hold until every result is back
  task automatic settle();
    @(negedge clk);
    smp_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // segments of steady motion with jitter, glitches, half-turn jumps and extremes
  task automatic drive_motion(input int n);
    int speed, span, seg_left, r;
    seg_left = 0;
    speed    = 0;
    for (int k = 0; k < n; k++) begin
      if (seg_left == 0) begin
        case ($urandom_range(2))
          0:       span = 40;
          1:       span = 600;
          default: span = 2500;
        endcase
        speed    = int'($urandom_range(2 * span)) - span;
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      r = $urandom_range(99);
      if (r < 7) begin
        push_sample($urandom_range(ANGLE_MAX));
      end else if (r < 9) begin
        pos = (pos + 8192) % (ANGLE_MAX + 1);
        push_sample(pos);
      end else if (r < 11) begin
        push_sample($urandom_range(1) ? ANGLE_MAX : 0);
      end else begin
        if ($urandom_range(9) == 0) speed += int'($urandom_range(20)) - 10;
        pos = ((pos + speed + int'($urandom_range(6)) - 3) % (ANGLE_MAX + 1)
               + ANGLE_MAX + 1) % (ANGLE_MAX + 1);
        push_sample(pos);
      end
    end
  endtask

  initial begin
    smp_ch.valid     = 1'b0;
    smp_ch.raw_angle = '0;
    samples_sent = 0;
    reg_writes   = 0;
    pos          = 900;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the ring with extremes and half-turn deltas, then run at reset limits
    foreach (directed_seq[i]) push_sample(directed_seq[i]);
    drive_motion(180);
    settle();

    // tightest limits: every moving sample gets replaced
    write_reg(egf_pkg::REG_SPEED_LIMIT, 0);
    write_reg(egf_pkg::REG_CHANGE_LIMIT, 0);
    drive_motion(190);
    settle();

    // widest limits, no idling on either side
    write_reg(egf_pkg::REG_SPEED_LIMIT, 8192);
    write_reg(egf_pkg::REG_CHANGE_LIMIT, 16384);
    no_idle = 1'b1;
    drive_motion(190);
    settle();
    no_idle = 1'b0;

    write_reg(egf_pkg::REG_SPEED_LIMIT, $urandom_range(50, 3000));
    write_reg(egf_pkg::REG_CHANGE_LIMIT, $urandom_range(10, 1000));
    drive_motion(190);
    settle();

    // bit above the speed register width is dropped; unknown index is ignored
    write_reg(egf_pkg::REG_SPEED_LIMIT, 16384 + 300);
    write_reg(egf_pkg::REG_CHANGE_LIMIT, $urandom_range(100, 700));
    write_reg(egf_pkg::CFG_INDEX_W'(5), $urandom_range(32767));
    drive_motion(190);
    settle();

    write_reg(egf_pkg::REG_SPEED_LIMIT, $urandom_range(8192));
    write_reg(egf_pkg::REG_CHANGE_LIMIT, $urandom_range(16384));
    drive_motion(190);
    settle();

    repeat (60) @(posedge clk);
    $display("Sent %0d samples over %0d register writes; %0d results checked.",
             samples_sent, reg_writes, results_seen);
    $display("%0d results were estimates replacing rejected samples.", estimates_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/egf_pkg.sv
rtl/egf_if.sv
rtl/egf_addsub.sv
rtl/encoder_glitch_filter.sv
tb/sv/egf_checker.sv
tb/sv/tb.sv
